// ----- sv/ntpt_pkg.sv -----
// Package for the nearest three point table.
// Holds the item structs, operation codes, controller states and command types.
// No dependencies.
package ntpt_pkg;

  // Reset value of the distance limit: 300.0 in 20.12 format.
  localparam logic [41:0] LIMIT_RESET = 42'd1228800;

  // Operation codes carried in the input item.
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Which result the datapath puts into the output register.
  typedef enum logic [1:0] {
    RES_ZERO        = 2'd0,
    RES_CREATE_OK   = 2'd1,
    RES_CREATE_FAIL = 2'd2,
    RES_QUERY       = 2'd3
  } res_sel_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_QUERY,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One input item.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic signed [31:0] intensity;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  create_slot;
    logic        create_failed;
    logic [3:0]  first_slot;
    logic        first_found;
    logic [41:0] first_distance;
    logic [3:0]  second_slot;
    logic        second_found;
    logic [41:0] second_distance;
    logic [3:0]  third_slot;
    logic        third_found;
    logic [41:0] third_distance;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     create_write;
    logic     clear_all;
    logic     query_init;
    logic     issue;
    logic     load_result;
    res_sel_e sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_used;
    logic pipe_busy;
  } sts_t;

endpackage

// ----- sv/ntpt_ctrl.sv -----
// Controller state machine of the nearest three point table.
// Sequences create, query and clear and owns the result handshake. Uses ntpt_pkg.
module ntpt_ctrl #(
  parameter int unsigned SLOT_COUNT = 16,
  localparam int unsigned SW = $clog2(SLOT_COUNT)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ntpt_pkg::cmd_t  cmd_o,
  input  ntpt_pkg::sts_t  sts_i,
  output logic [SW-1:0]   addr_o
);
  import ntpt_pkg::*;

  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  state_e        state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  res_sel_e      sel_q, sel_d;
  logic          out_valid_q, out_valid_d;

  // Next state, slot counter and pending result kind.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          unique case (op_e'(in_op_i))
            OP_CREATE: state_d = ST_CREATE;
            OP_QUERY:  state_d = ST_QUERY;
            default: begin
              state_d = ST_DONE;
              sel_d   = RES_ZERO;
            end
          endcase
        end
      end
      ST_CREATE: begin
        if (!sts_i.slot_used) begin
          state_d = ST_DONE;
          sel_d   = RES_CREATE_OK;
        end else if (cnt_q == LAST_SLOT) begin
          state_d = ST_DONE;
          sel_d   = RES_CREATE_FAIL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_QUERY: begin
        if (cnt_q == LAST_SLOT) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
          sel_d   = RES_QUERY;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath for the current state.
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.capture    = in_valid_i;
        cmd_o.clear_all  = in_valid_i && (in_op_i == OP_CLEAR);
        cmd_o.query_init = in_valid_i && (in_op_i == OP_QUERY);
      end
      ST_CREATE: cmd_o.create_write = !sts_i.slot_used;
      ST_QUERY:  cmd_o.issue = 1'b1;
      ST_DRAIN:  cmd_o.issue = 1'b0;
      ST_DONE:   cmd_o.load_result = !out_valid_q || out_ready_i;
      default:   cmd_o.issue = 1'b0;
    endcase
  end

  // The output register holds a result until its transfer.
  always_comb begin
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sel_q       <= RES_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign addr_o      = cnt_q;

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken result");

  // Create only writes a free slot.
  a_create_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.create_write |-> !sts_i.slot_used)
    else $error("create wrote a used slot");

  // The create, clear, query-init and issue commands never overlap.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.create_write, cmd_o.clear_all, cmd_o.query_init, cmd_o.issue}))
    else $error("overlapping datapath commands");

  // The query result is only formed after the distance pipeline is empty.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !sts_i.pipe_busy) |=> (state_q == ST_DONE && sel_q == RES_QUERY))
    else $error("drain did not finish the query");

endmodule

// ----- sv/ntpt_datapath.sv -----
// Datapath of the nearest three point table: slot memory, used bits,
// pipelined distance unit, best-three registers and result register. Uses ntpt_pkg.
module ntpt_datapath #(
  parameter int unsigned SLOT_COUNT = 16,
  localparam int unsigned SW = $clog2(SLOT_COUNT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntpt_pkg::in_item_t  in_item_i,
  input  logic                cfg_valid_i,
  input  logic [41:0]         cfg_data_i,
  input  ntpt_pkg::cmd_t      cmd_i,
  output ntpt_pkg::sts_t      sts_o,
  input  logic [SW-1:0]       addr_i,
  output ntpt_pkg::out_item_t out_item_o
);
  import ntpt_pkg::*;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic signed [31:0] intensity;
  } entry_t;

  in_item_t         item_q;
  logic [41:0]      limit_q;
  logic [SLOT_COUNT-1:0] used_q;
  entry_t           mem_q [SLOT_COUNT];
  entry_t           rd_q;
  logic [SW-1:0]    cslot_q;

  // Pipeline control: valid, slot used and slot number per stage.
  logic             v1_q, v2_q, v3_q, v4_q;
  logic             u1_q, u2_q, u3_q, u4_q;
  logic [SW-1:0]    s1_q, s2_q, s3_q, s4_q;
  logic signed [20:0] dx_q, dy_q, dz_q;
  logic signed [20:0] dx_d, dy_d, dz_d;
  logic signed [41:0] px_d, py_d, pz_d;
  logic [40:0]      sqx_q, sqy_q, sqz_q;
  logic [41:0]      sum_q, sum_d;

  // Best three so far, nearest first.
  logic [41:0]      dist_q [3];
  logic [SW-1:0]    slot_q [3];
  logic             fnd_q  [3];
  logic             lt0, lt1, lt2;

  out_item_t        out_q, out_d;

  // Distance limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Captured item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
  end

  // Used bits: cleared together, set one at a time by create.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.clear_all) begin
      used_q <= '0;
    end else if (cmd_i.create_write) begin
      used_q[addr_i] <= 1'b1;
    end
  end

  // Slot memory: one write port for create, one registered read port for query.
  always_ff @(posedge clk_i) begin
    if (cmd_i.create_write) begin
      mem_q[addr_i] <= '{pos_x: item_q.pos_x, pos_y: item_q.pos_y,
                         pos_z: item_q.pos_z, intensity: item_q.intensity};
      cslot_q       <= addr_i;
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign sts_o.slot_used = used_q[addr_i];
  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;

  // Differences, query minus entry.
  assign dx_d = 21'(item_q.pos_x) - 21'(rd_q.pos_x);
  assign dy_d = 21'(item_q.pos_y) - 21'(rd_q.pos_y);
  assign dz_d = 21'(item_q.pos_z) - 21'(rd_q.pos_z);

  // Squares; each is at most 2^40 and fits the 42-bit product exactly.
  assign px_d = 42'(dx_q) * 42'(dx_q);
  assign py_d = 42'(dy_q) * 42'(dy_q);
  assign pz_d = 42'(dz_q) * 42'(dz_q);

  // Weighted sum, with the y term divided by 16.
  assign sum_d = 42'(sqx_q) + 42'(sqy_q[40:4]) + 42'(sqz_q);

  // Pipeline valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    u1_q  <= used_q[addr_i];
    s1_q  <= addr_i;
    u2_q  <= u1_q;
    s2_q  <= s1_q;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    dz_q  <= dz_d;
    u3_q  <= u2_q;
    s3_q  <= s2_q;
    sqx_q <= px_d[40:0];
    sqy_q <= py_d[40:0];
    sqz_q <= pz_d[40:0];
    u4_q  <= u3_q;
    s4_q  <= s3_q;
    sum_q <= sum_d;
  end

  // Insert the new distance; strict compares keep the earlier slot on a tie.
  assign lt0 = sum_q < dist_q[0];
  assign lt1 = sum_q < dist_q[1];
  assign lt2 = sum_q < dist_q[2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_init) begin
      for (int k = 0; k < 3; k++) begin
        dist_q[k] <= limit_q;
        slot_q[k] <= '0;
        fnd_q[k]  <= 1'b0;
      end
    end else if (v4_q && u4_q) begin
      if (lt0) begin
        dist_q[2] <= dist_q[1];
        slot_q[2] <= slot_q[1];
        fnd_q[2]  <= fnd_q[1];
        dist_q[1] <= dist_q[0];
        slot_q[1] <= slot_q[0];
        fnd_q[1]  <= fnd_q[0];
        dist_q[0] <= sum_q;
        slot_q[0] <= s4_q;
        fnd_q[0]  <= 1'b1;
      end else if (lt1) begin
        dist_q[2] <= dist_q[1];
        slot_q[2] <= slot_q[1];
        fnd_q[2]  <= fnd_q[1];
        dist_q[1] <= sum_q;
        slot_q[1] <= s4_q;
        fnd_q[1]  <= 1'b1;
      end else if (lt2) begin
        dist_q[2] <= sum_q;
        slot_q[2] <= s4_q;
        fnd_q[2]  <= 1'b1;
      end
    end
  end

  // Result formatting.
  always_comb begin
    out_d = '0;
    unique case (cmd_i.sel)
      RES_CREATE_OK:   out_d.create_slot = 4'(cslot_q);
      RES_CREATE_FAIL: out_d.create_failed = 1'b1;
      RES_QUERY: begin
        out_d.first_slot      = 4'(slot_q[0]);
        out_d.first_found     = fnd_q[0];
        out_d.first_distance  = dist_q[0];
        out_d.second_slot     = 4'(slot_q[1]);
        out_d.second_found    = fnd_q[1];
        out_d.second_distance = dist_q[1];
        out_d.third_slot      = 4'(slot_q[2]);
        out_d.third_found     = fnd_q[2];
        out_d.third_distance  = dist_q[2];
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

// ----- sv/nearest_three_point_table.sv -----
// Nearest three point table: a table of point entries searched for the three
// nearest entries under a configurable distance limit.
// Channels: in (valid/ready, in_item_i), out (valid/ready, out_item_o) and a
// write-only configuration channel that sets the distance limit.
// Every accepted item gives exactly one result. Operation create scans the
// used bits from slot 0 and takes the first free slot. Query streams every
// slot through the memory read port and a pipeline of difference, square and
// sum registers, one slot per cycle. Clear and the unused operation code go
// straight to the result. The result sits in an output register, so the next
// item is accepted while a result waits; if the receiver stalls, the following
// result waits in the controller until the register frees, and input stays
// blocked until then. Reset frees every slot and sets the limit to 300.0
// (20.12 format). The configuration channel is always ready; the user must
// write it only while the block is idle, and the block itself does not
// enforce this.
module nearest_three_point_table #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ntpt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntpt_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [41:0]         cfg_data_i
);
  import ntpt_pkg::*;

  localparam int unsigned SW = $clog2(SLOT_COUNT);

  cmd_t          cmd;
  sts_t          sts;
  logic [SW-1:0] addr;

  assign cfg_ready_o = 1'b1;

  // Controller.
  ntpt_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_op_i     (in_item_i.operation),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .addr_o      (addr)
  );

  // Datapath.
  ntpt_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .addr_i      (addr),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- tb/ntpt_tb_pkg.sv -----
// Scoreboard for the nearest three point table testbench: it predicts the
// result of every accepted item and checks each returned result against it.
// Depends on ntpt_pkg for the item structs, operation codes and reset limit.
package ntpt_tb_pkg;
  import ntpt_pkg::*;

  localparam int unsigned SLOTS     = 16;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [41:0] LIMIT_MAX = '1;

  class nearest_table_scoreboard;
    logic [41:0]        limit;
    bit                 used [SLOTS];
    logic signed [19:0] ent_x [SLOTS];
    logic signed [19:0] ent_y [SLOTS];
    logic signed [19:0] ent_z [SLOTS];
    out_item_t          pending [$];
    int unsigned        errors;

    function new();
      limit = LIMIT_RESET;
      foreach (used[i]) used[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_limit(logic [41:0] value);
      limit = value;
    endfunction

    // Weighted squared distance between a query point and a stored entry.
    function logic [41:0] weighted_distance(in_item_t q, int unsigned s);
      longint dx, dy, dz;
      dx = longint'($signed(q.pos_x)) - longint'(ent_x[s]);
      dy = longint'($signed(q.pos_y)) - longint'(ent_y[s]);
      dz = longint'($signed(q.pos_z)) - longint'(ent_z[s]);
      return 42'(dx * dx + (dy * dy) / 16 + dz * dz);
    endfunction

    // Work out the result of one accepted item and queue it.
    function void note_input(in_item_t item);
      out_item_t   res;
      logic [41:0] best_d [3];
      logic [3:0]  best_s [3];
      logic        best_f [3];
      logic [41:0] d;
      res = '0;
      case (item.operation)
        OP_CREATE: begin
          res.create_failed = 1'b1;
          for (int s = 0; s < SLOTS; s++) begin
            if (!used[s]) begin
              used[s]  = 1'b1;
              ent_x[s] = item.pos_x;
              ent_y[s] = item.pos_y;
              ent_z[s] = item.pos_z;
              res.create_failed = 1'b0;
              res.create_slot   = 4'(s);
              break;
            end
          end
        end
        OP_QUERY: begin
          for (int k = 0; k < 3; k++) begin
            best_d[k] = limit;
            best_s[k] = '0;
            best_f[k] = 1'b0;
          end
          // Strict comparison keeps the earlier slot on a tie.
          for (int s = 0; s < SLOTS; s++) begin
            if (used[s]) begin
              d = weighted_distance(item, s);
              for (int k = 0; k < 3; k++) begin
                if (d < best_d[k]) begin
                  for (int j = 2; j > k; j--) begin
                    best_d[j] = best_d[j-1];
                    best_s[j] = best_s[j-1];
                    best_f[j] = best_f[j-1];
                  end
                  best_d[k] = d;
                  best_s[k] = 4'(s);
                  best_f[k] = 1'b1;
                  break;
                end
              end
            end
          end
          res.first_slot      = best_s[0];
          res.first_found     = best_f[0];
          res.first_distance  = best_d[0];
          res.second_slot     = best_s[1];
          res.second_found    = best_f[1];
          res.second_distance = best_d[1];
          res.third_slot      = best_s[2];
          res.third_found     = best_f[2];
          res.third_distance  = best_d[2];
        end
        OP_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
        end
        default: begin
          // The unused code leaves the table alone and returns all zeros.
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check_field(string name, logic [41:0] want, logic [41:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one returned result with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("create_slot", 42'(want.create_slot), 42'(got.create_slot));
      check_field("create_failed", 42'(want.create_failed), 42'(got.create_failed));
      check_field("first_slot", 42'(want.first_slot), 42'(got.first_slot));
      check_field("first_found", 42'(want.first_found), 42'(got.first_found));
      check_field("first_distance", want.first_distance, got.first_distance);
      check_field("second_slot", 42'(want.second_slot), 42'(got.second_slot));
      check_field("second_found", 42'(want.second_found), 42'(got.second_found));
      check_field("second_distance", want.second_distance, got.second_distance);
      check_field("third_slot", 42'(want.third_slot), 42'(got.third_slot));
      check_field("third_found", 42'(want.third_found), 42'(got.third_found));
      check_field("third_distance", want.third_distance, got.third_distance);
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top testbench for the nearest three point table: directed items, then four
// phases of clustered random items under varied idling and distance limits.
// Depends on ntpt_pkg, ntpt_tb_pkg and the nearest_three_point_table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ntpt_pkg::*;
  import ntpt_tb_pkg::*;

  localparam int unsigned RANDOM_PER_PHASE = 381;
  localparam int unsigned QUIET_LIMIT      = 2000;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam logic signed [19:0] POS_MAX   = 20'sh7FFFF;
  localparam logic signed [19:0] POS_MIN   = 20'sh80000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [41:0] cfg_data_i  = '0;

  nearest_table_scoreboard table_sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  logic signed [19:0] center_x, center_y, center_z;

  nearest_three_point_table #(.SLOT_COUNT(SLOTS)) DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver side: ready is redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Observe every transfer at the rising edge and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) table_sb.note_input(in_item_i);
      if (out_valid_o && out_ready_i) table_sb.check_result(out_item_o);
      if (cfg_valid_i && cfg_ready_o) table_sb.set_limit(cfg_data_i);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: a long stretch without any transfer means the block is stuck.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Present one item after a random idle gap and hold it until it is taken.
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (table_sb.pending.size() != 0);
  endtask

  // The limit is only changed while the table is idle.
  task automatic write_limit(input logic [41:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [1:0] op, logic signed [19:0] x,
                                         logic signed [19:0] y, logic signed [19:0] z,
                                         logic signed [31:0] level);
    in_item_t it;
    it.operation = op;
    it.pos_x     = x;
    it.pos_y     = y;
    it.pos_z     = z;
    it.intensity = level;
    return it;
  endfunction

  function automatic logic signed [19:0] near(logic signed [19:0] c, int unsigned spread);
    return c + 20'($urandom_range(2 * spread)) - 20'(spread);
  endfunction

  task automatic pick_center();
    center_x = 20'($urandom);
    center_y = 20'($urandom);
    center_z = 20'($urandom);
  endtask

  // Mostly creates and queries around one cluster so that queries find
  // entries under the limit; a few items use fully random points.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 43) it.operation = OP_CREATE;
    else if (pick < 94) it.operation = OP_QUERY;
    else if (pick < 97) it.operation = OP_CLEAR;
    else it.operation = OP_UNUSED;
    it.intensity = $urandom;
    if ($urandom_range(9) < 8) begin
      it.pos_x = near(center_x, 1024);
      it.pos_y = near(center_y, 4096);
      it.pos_z = near(center_z, 1024);
    end else begin
      it.pos_x = 20'($urandom);
      it.pos_y = 20'($urandom);
      it.pos_z = 20'($urandom);
    end
    return it;
  endfunction

  task automatic run_directed();
    // Query an empty table, then the unused operation code.
    send_item(make_item(OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 32'sd0));
    send_item(make_item(OP_UNUSED, POS_MAX, POS_MIN, POS_MAX, -32'sd1));
    // Entries at both corners, two equal entries for a tie, one close entry.
    send_item(make_item(OP_CREATE, POS_MAX, POS_MAX, POS_MAX, 32'sh7FFFFFFF));
    send_item(make_item(OP_CREATE, POS_MIN, POS_MIN, POS_MIN, 32'sh80000000));
    send_item(make_item(OP_CREATE, 20'sd0, 20'sd0, 20'sd0, 32'sd0));
    send_item(make_item(OP_CREATE, 20'sd0, 20'sd0, 20'sd0, -32'sd1));
    send_item(make_item(OP_CREATE, 20'sd16, 20'sd64, 20'sd0, 32'sd5));
    send_item(make_item(OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 32'sd0));
    send_item(make_item(OP_QUERY, POS_MAX, POS_MAX, POS_MAX, 32'sd0));
    // A distance equal to the limit is not reported.
    write_limit(42'd512);
    send_item(make_item(OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 32'sd0));
    write_limit(42'd0);
    send_item(make_item(OP_QUERY, 20'sd0, 20'sd0, 20'sd0, 32'sd0));
    write_limit(LIMIT_RESET);
    // Fill the rest of the table, then one create too many, then clear.
    for (int s = 5; s < SLOTS; s++) begin
      send_item(make_item(OP_CREATE, 20'(s * 37), 20'(-s * 91), 20'(s * 5), 32'(s)));
    end
    send_item(make_item(OP_CREATE, 20'sd1, 20'sd1, 20'sd1, 32'sd1));
    send_item(make_item(OP_CLEAR, 20'sd0, 20'sd0, 20'sd0, 32'sd0));
    // Largest possible distance under the widest limit.
    write_limit(LIMIT_MAX);
    send_item(make_item(OP_CREATE, POS_MAX, POS_MAX, POS_MAX, 32'sd0));
    send_item(make_item(OP_QUERY, POS_MIN, POS_MIN, POS_MIN, 32'sd0));
  endtask

  initial begin
    int unsigned send_idle  [4];
    int unsigned recv_stall [4];
    in_item_t    item;
    logic [41:0] phase_limit;
    send_idle  = '{0, 73, 0, 38};
    recv_stall = '{0, 0, 73, 38};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    // Random phases, each with its own idling pattern and limit.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       phase_limit = LIMIT_RESET;
        1:       phase_limit = LIMIT_MAX;
        2:       phase_limit = 42'($urandom_range(1 << 22));
        default: phase_limit = 42'($urandom_range(4 * 1228800));
      endcase
      write_limit(phase_limit);
      send_idle_pct  = send_idle[ph];
      recv_stall_pct = recv_stall[ph];
      pick_center();
      repeat (RANDOM_PER_PHASE) begin
        item = random_item();
        if ($urandom_range(299) == 0) wait_drained();
        send_item(item);
        if (item.operation == OP_CLEAR) pick_center();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (table_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
